// File: design/mpte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpte_pkg: MessagePack token encoder definitions
// Token codes, format tags and the encoded-beat buffer type.
// ----------------------------------------------------------------------------
package mpte_pkg;

  localparam int unsigned MaxBytes = 9;
  localparam int unsigned CntW     = 4;

  typedef enum logic [3:0] {
    CMD_NULL   = 4'd0,
    CMD_BOOL   = 4'd1,
    CMD_INT32  = 4'd2,
    CMD_UINT32 = 4'd3,
    CMD_DOUBLE = 4'd4,
    CMD_STR    = 4'd5,
    CMD_MAP    = 4'd6,
    CMD_ARRAY  = 4'd7,
    CMD_BYTE   = 4'd8
  } cmd_e;

  localparam logic [7:0] TagNil     = 8'hC0;
  localparam logic [7:0] TagFalse   = 8'hC2;
  localparam logic [7:0] TagTrue    = 8'hC3;
  localparam logic [7:0] TagUint32  = 8'hCE;
  localparam logic [7:0] TagInt32   = 8'hD2;
  localparam logic [7:0] TagFloat64 = 8'hCB;
  localparam logic [7:0] TagFixStr  = 8'hA0;
  localparam logic [7:0] TagStr8    = 8'hD9;
  localparam logic [7:0] TagStr16   = 8'hDA;
  localparam logic [7:0] TagStr32   = 8'hDB;
  localparam logic [7:0] TagFixMap  = 8'h80;
  localparam logic [7:0] TagMap16   = 8'hDE;
  localparam logic [7:0] TagMap32   = 8'hDF;
  localparam logic [7:0] TagFixArr  = 8'h90;
  localparam logic [7:0] TagArr16   = 8'hDC;
  localparam logic [7:0] TagArr32   = 8'hDD;

  // bytes[0] goes out first
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
  } enc_t;

endpackage
`default_nettype wire

// File: design/mpte_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpte_in_if: token input channel
// Valid/ready channel carrying one token per beat.
// ----------------------------------------------------------------------------
interface mpte_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [63:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface
`default_nettype wire

// File: design/mpte_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpte_out_if: encoded byte output channel
// Valid/ready channel carrying one stream byte per beat.
// ----------------------------------------------------------------------------
interface mpte_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_of_item;
  logic [31:0] total_bytes;

  modport source (output valid, output out_byte, output last_of_item,
                  output total_bytes, input ready);
  modport sink   (input valid, input out_byte, input last_of_item,
                  input total_bytes, output ready);
endinterface
`default_nettype wire

// File: design/messagepack_token_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// messagepack_token_encoder_core: streaming MessagePack token encoder
// Turns tokens into MessagePack bytes with a running byte total.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  takes one token per beat (cmd, value). out_o gives one stream byte
//   per beat with last_of_item on the final byte of the token and the
//   wrapping byte total including that byte.
//   A token accepted is encoded combinationally into the byte buffer; its
//   bytes then move one at a time from the buffer to the output register.
//   The buffer drains one byte per cycle while the output register is free,
//   and a token holds the input until its bytes have drained: payload bytes,
//   nil and bool are 1 byte, int32/uint32 5, a double 9, headers 1 to 5.
//   Tokens that encode to nothing (oversized counts, unused codes) leave the
//   buffer empty. The next token is taken in the cycle its predecessor's
//   last byte moves to the output register.
//   When the receiver stalls, the output register and buffer hold and
//   in_i.ready is low while the buffer has more than its final byte left,
//   or holds that byte and the output register cannot take it.
//   Reset empties the buffer and output register and clears the total.
// ----------------------------------------------------------------------------
module messagepack_token_encoder_core #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  mpte_in_if.sink      in_i,
  mpte_out_if.source   out_o
);
  import mpte_pkg::*;

  enc_t                     enc;
  logic [MaxBytes-1:0][7:0] sb_q, sb_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [31:0]              tot_q, tot_d;
  logic                     ov_q, ov_d;
  logic [7:0]               ob_q, ob_d;
  logic                     ol_q, ol_d;
  logic [31:0]              ot_q, ot_d;
  logic                     o_free, emit, in_acc;

  mpte_encoder #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_enc (
    .cmd_i   (in_i.cmd),
    .value_i (in_i.value),
    .enc_o   (enc)
  );

  assign o_free     = !ov_q || out_o.ready;
  assign emit       = (cnt_q != '0) && o_free;
  assign in_i.ready = (cnt_q == '0) || ((cnt_q == CntW'(1)) && o_free);
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    sb_d  = sb_q;
    cnt_d = cnt_q;
    tot_d = tot_q;
    ov_d  = ov_q;
    ob_d  = ob_q;
    ol_d  = ol_q;
    ot_d  = ot_q;
    if (o_free) begin
      ov_d = emit;
    end
    if (emit) begin
      ob_d  = sb_q[0];
      ol_d  = (cnt_q == CntW'(1));
      ot_d  = tot_q + 32'd1;
      tot_d = tot_q + 32'd1;
      sb_d  = {8'h00, sb_q[MaxBytes-1:1]};
      cnt_d = cnt_q - CntW'(1);
    end
    if (in_acc) begin
      sb_d  = enc.bytes;
      cnt_d = enc.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      tot_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      tot_q <= tot_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sb_q <= sb_d;
    ob_q <= ob_d;
    ol_q <= ol_d;
    ot_q <= ot_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.out_byte     = ob_q;
  assign out_o.last_of_item = ol_q;
  assign out_o.total_bytes  = ot_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxBytes))
    else $error("byte buffer count out of range");

  a_acc_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (cnt_q == '0) || (emit && (cnt_q == CntW'(1))))
    else $error("token accepted while buffer still holds bytes");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> tot_q == $past(tot_q) + 32'd1)
    else $error("byte total did not advance on emission");

  a_total_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> ot_q == tot_q)
    else $error("output total differs from running total");

endmodule
`default_nettype wire

// File: design/mpte_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpte_encoder: token to MessagePack bytes
// Picks the format and lays out the big-endian bytes of one token.
// ----------------------------------------------------------------------------
module mpte_encoder #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic [3:0]    cmd_i,
  input  wire logic [63:0]   value_i,
  output mpte_pkg::enc_t     enc_o
);
  import mpte_pkg::*;

  localparam logic [63:0] CountMask =
    (COUNT_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << COUNT_WIDTH) - 64'd1);

  logic [63:0] c;
  logic        big;

  assign c   = value_i & CountMask;
  assign big = |c[63:32];

  always_comb begin
    enc_o = '0;
    unique case (cmd_i)
      CMD_NULL: begin
        enc_o.bytes[0] = TagNil;
        enc_o.cnt      = 4'd1;
      end
      CMD_BOOL: begin
        enc_o.bytes[0] = (|value_i[31:0]) ? TagTrue : TagFalse;
        enc_o.cnt      = 4'd1;
      end
      CMD_INT32, CMD_UINT32: begin
        enc_o.bytes[0] = (cmd_i == CMD_INT32) ? TagInt32 : TagUint32;
        enc_o.bytes[1] = value_i[31:24];
        enc_o.bytes[2] = value_i[23:16];
        enc_o.bytes[3] = value_i[15:8];
        enc_o.bytes[4] = value_i[7:0];
        enc_o.cnt      = 4'd5;
      end
      CMD_DOUBLE: begin
        enc_o.bytes[0] = TagFloat64;
        for (int i = 0; i < 8; i++) begin
          enc_o.bytes[i+1] = value_i[8*(7-i) +: 8];
        end
        enc_o.cnt      = 4'd9;
      end
      CMD_STR: begin
        if (c < 64'd32) begin
          enc_o.bytes[0] = TagFixStr | {3'b000, c[4:0]};
          enc_o.cnt      = 4'd1;
        end else if (c < 64'd256) begin
          enc_o.bytes[0] = TagStr8;
          enc_o.bytes[1] = c[7:0];
          enc_o.cnt      = 4'd2;
        end else if (c < 64'd65535) begin
          enc_o.bytes[0] = TagStr16;
          enc_o.bytes[1] = c[15:8];
          enc_o.bytes[2] = c[7:0];
          enc_o.cnt      = 4'd3;
        end else if (!big) begin
          enc_o.bytes[0] = TagStr32;
          enc_o.bytes[1] = c[31:24];
          enc_o.bytes[2] = c[23:16];
          enc_o.bytes[3] = c[15:8];
          enc_o.bytes[4] = c[7:0];
          enc_o.cnt      = 4'd5;
        end
      end
      CMD_MAP, CMD_ARRAY: begin
        if (c < 64'd16) begin
          enc_o.bytes[0] = ((cmd_i == CMD_MAP) ? TagFixMap : TagFixArr) |
                           {4'b0000, c[3:0]};
          enc_o.cnt      = 4'd1;
        end else if (c < 64'd65535) begin
          enc_o.bytes[0] = (cmd_i == CMD_MAP) ? TagMap16 : TagArr16;
          enc_o.bytes[1] = c[15:8];
          enc_o.bytes[2] = c[7:0];
          enc_o.cnt      = 4'd3;
        end else if (!big) begin
          enc_o.bytes[0] = (cmd_i == CMD_MAP) ? TagMap32 : TagArr32;
          enc_o.bytes[1] = c[31:24];
          enc_o.bytes[2] = c[23:16];
          enc_o.bytes[3] = c[15:8];
          enc_o.bytes[4] = c[7:0];
          enc_o.cnt      = 4'd5;
        end
      end
      CMD_BYTE: begin
        enc_o.bytes[0] = value_i[7:0];
        enc_o.cnt      = 4'd1;
      end
      default: begin
        enc_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: test/tb_messagepack_token_encoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_messagepack_token_encoder_core: token encoder testbench
// Drives MessagePack tokens through the input channel and rebuilds every
// encoded beat (byte, end-of-token flag, running total) in a local encoder
// model. Corner tokens come first. Random header/payload streams follow,
// under three idle mixes with one pause that drains the output.
// ----------------------------------------------------------------------------
module tb_messagepack_token_encoder_core;
  import mpte_pkg::*;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned ShowLimit  = 10;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] total;
  } stream_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  mpte_in_if  tok_if ();
  mpte_out_if byte_if ();

  messagepack_token_encoder_core #(
    .COUNT_WIDTH(CountWidth)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (tok_if),
    .out_o (byte_if)
  );

  always #1 clk = ~clk;

  int unsigned  src_idle_pct = 18;
  int unsigned  snk_idle_pct = 66;
  int unsigned  mismatches   = 0;
  int unsigned  tokens_taken = 0;
  int unsigned  beats_seen   = 0;
  int unsigned  idle_cycles  = 0;
  logic [31:0]  stream_total = '0;
  logic [7:0]   tok_bytes[$];
  stream_beat_t expected_beats[$];

  // ---------------------------------------------------------------- encoder model
  function automatic void push_be(logic [63:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) begin
      tok_bytes.push_back(v[i*8 +: 8]);
    end
  endfunction

  function automatic void push_header(logic [63:0] raw, logic [63:0] fix_lim,
                                      logic [7:0] fix_tag, bit has8, logic [7:0] tag8,
                                      logic [63:0] lim16, logic [7:0] tag16,
                                      logic [7:0] tag32);
    logic [63:0] c;
    c = (CountWidth >= 64) ? raw : raw & ((64'd1 << CountWidth) - 64'd1);
    if (c < fix_lim) begin
      tok_bytes.push_back(fix_tag | c[7:0]);
    end else if (has8 && c < 64'd256) begin
      tok_bytes.push_back(tag8);
      push_be(c, 1);
    end else if (c < lim16) begin
      tok_bytes.push_back(tag16);
      push_be(c, 2);
    end else if (c <= 64'hFFFF_FFFF) begin
      tok_bytes.push_back(tag32);
      push_be(c, 4);
    end
  endfunction

  function automatic void encode_token(logic [3:0] cmd, logic [63:0] value);
    tok_bytes.delete();
    case (cmd)
      CMD_NULL:   tok_bytes.push_back(TagNil);
      CMD_BOOL:   tok_bytes.push_back((value[31:0] != '0) ? TagTrue : TagFalse);
      CMD_INT32: begin
        tok_bytes.push_back(TagInt32);
        push_be({32'd0, value[31:0]}, 4);
      end
      CMD_UINT32: begin
        tok_bytes.push_back(TagUint32);
        push_be({32'd0, value[31:0]}, 4);
      end
      CMD_DOUBLE: begin
        tok_bytes.push_back(TagFloat64);
        push_be(value, 8);
      end
      CMD_STR:    push_header(value, 64'd32, TagFixStr, 1'b1, TagStr8, 64'd65535,
                              TagStr16, TagStr32);
      CMD_MAP:    push_header(value, 64'd16, TagFixMap, 1'b0, TagMap16, 64'hFFFF,
                              TagMap16, TagMap32);
      CMD_ARRAY:  push_header(value, 64'd16, TagFixArr, 1'b0, TagArr16, 64'hFFFF,
                              TagArr16, TagArr32);
      CMD_BYTE:   tok_bytes.push_back(value[7:0]);
      default: ;
    endcase
    foreach (tok_bytes[k]) begin
      stream_total = stream_total + 32'd1;
      expected_beats.push_back('{tok_bytes[k], k == tok_bytes.size() - 1, stream_total});
    end
  endfunction

  // ---------------------------------------------------------------- checking
  function automatic void report_field(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= ShowLimit) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endfunction

  function automatic void check_beat(stream_beat_t got);
    stream_beat_t want;
    beats_seen++;
    if (expected_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= ShowLimit) begin
        $display("%0t: unexpected beat, got byte 0x%02h last %0b total %0d",
                 $time, got.data, got.last, got.total);
      end
      return;
    end
    want = expected_beats.pop_front();
    if (got.data !== want.data) begin
      report_field("out_byte", 32'(want.data), 32'(got.data));
    end
    if (got.last !== want.last) begin
      report_field("last_of_item", 32'(want.last), 32'(got.last));
    end
    if (got.total !== want.total) begin
      report_field("total_bytes", want.total, got.total);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (tok_if.valid && tok_if.ready) begin
        encode_token(tok_if.cmd, tok_if.value);
        tokens_taken++;
      end
      if (byte_if.valid && byte_if.ready) begin
        check_beat('{byte_if.out_byte, byte_if.last_of_item, byte_if.total_bytes});
      end
    end
  end

  always @(posedge clk) begin
    byte_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (tok_if.valid && tok_if.ready) || (byte_if.valid && byte_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("messagepack_token_encoder_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_token(input logic [3:0] cmd, input logic [63:0] value);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      tok_if.valid <= 1'b0;
      @(posedge clk);
    end
    tok_if.valid <= 1'b1;
    tok_if.cmd   <= cmd;
    tok_if.value <= value;
    @(posedge clk);
    while (!tok_if.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    tok_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_count();
    case ($urandom_range(0, 7))
      0: return 64'($urandom_range(0, 40));
      1: return 64'($urandom_range(240, 300));
      2: return 64'($urandom_range(65530, 65540));
      3: return 64'($urandom_range(0, 20));
      4: return {32'd0, $urandom};
      5: return {$urandom, $urandom};
      6: return 64'hFFFF_FFFF - 64'($urandom_range(0, 3));
      default: return 64'($urandom_range(30, 34));
    endcase
  endfunction

  task automatic test_corner_tokens();
    send_token(CMD_NULL,   64'd0);
    send_token(CMD_BOOL,   64'hFFFF_FFFF_0000_0000);
    send_token(CMD_BOOL,   64'd1);
    send_token(CMD_INT32,  64'hDEAD_BEEF_8000_0000);
    send_token(CMD_UINT32, 64'h0000_0000_FFFF_FFFF);
    send_token(CMD_DOUBLE, 64'h0123_4567_89AB_CDEF);
    send_token(CMD_STR,    64'd31);
    send_token(CMD_STR,    64'd32);
    send_token(CMD_STR,    64'd255);
    send_token(CMD_STR,    64'd256);
    send_token(CMD_STR,    64'd65534);
    send_token(CMD_STR,    64'd65535);
    send_token(CMD_STR,    64'hFFFF_FFFF);
    send_token(CMD_STR,    64'h0000_0001_0000_0005);
    send_token(CMD_MAP,    64'd15);
    send_token(CMD_MAP,    64'd16);
    send_token(CMD_MAP,    64'hFFFE);
    send_token(CMD_MAP,    64'hFFFF);
    send_token(CMD_ARRAY,  64'd0);
    send_token(CMD_ARRAY,  64'd16);
    send_token(CMD_ARRAY,  64'hFFFE);
    send_token(CMD_ARRAY,  64'hFFFF_FFFF);
    send_token(CMD_BYTE,   64'd0);
    send_token(CMD_BYTE,   64'hFFFF_FFFF_FFFF_FFFF);
    send_token(4'(int'(CMD_BYTE) + 1), 64'hFFFF_FFFF_FFFF_FFFF);
    send_token(4'hF, 64'd0);
  endtask

  task automatic test_random_stream(input int unsigned src_pct, input int unsigned snk_pct,
                                    input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned body;
    logic [63:0] len;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        len = pick_count();
        send_token(CMD_STR, len);
        sent++;
        body = (len < 64'd6) ? int'(len) : $urandom_range(1, 5);
        repeat (body) begin
          send_token(CMD_BYTE, {$urandom, $urandom});
          sent++;
        end
      end else if (pick < 55) begin
        send_token(($urandom_range(0, 1) != 0) ? CMD_MAP : CMD_ARRAY, pick_count());
        sent++;
      end else if (pick < 60) begin
        send_token(4'($urandom_range(int'(CMD_BYTE) + 1, 15)), {$urandom, $urandom});
      end else begin
        send_token(4'($urandom_range(int'(CMD_NULL), int'(CMD_BYTE))),
                   {$urandom, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom});
        sent++;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    tok_if.valid  = 1'b0;
    tok_if.cmd    = CMD_NULL;
    tok_if.value  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_tokens();
    wait_drained();
    test_random_stream(18, 66, 145);
    wait_drained();
    test_random_stream(66, 18, 145);
    test_random_stream(0, 0, 145);
    wait_drained();
    repeat (TailCycles) @(posedge clk);

    if (expected_beats.size() != 0) begin
      $display("%0d expected beats never arrived", expected_beats.size());
    end
    $display("Sent %0d tokens: corner lengths and counts, all commands, unused codes,",
             tokens_taken);
    $display("random header/payload streams under three idle mixes; %0d beats checked",
             beats_seen);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("messagepack_token_encoder_core verification clean");
    end else begin
      $display("messagepack_token_encoder_core verification failed");
    end
    $finish;
  end

endmodule
